### design/alm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alm_pkg;

	localparam logic [3:0] CMD_INS_FRONT  = 4'd0;
	localparam logic [3:0] CMD_INS_REAR   = 4'd1;
	localparam logic [3:0] CMD_REM_FRONT  = 4'd2;
	localparam logic [3:0] CMD_REM_REAR   = 4'd3;
	localparam logic [3:0] CMD_REM_CUR    = 4'd4;
	localparam logic [3:0] CMD_SEARCH     = 4'd5;
	localparam logic [3:0] CMD_RETRIEVE   = 4'd6;
	localparam logic [3:0] CMD_PURGE      = 4'd7;
	localparam logic [3:0] CMD_CLEAR      = 4'd8;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NO_CUR    = 2'd3;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_TAIL_R,
		S_TAKE,
		S_TAKE_R,
		S_PLACE,
		S_LINKP,
		S_DROP,
		S_DROP_R,
		S_RR_R1,
		S_RR_R2,
		S_RC_R,
		S_RC_R2,
		S_SR_R,
		S_RT_R,
		S_PG_KEY,
		S_PG_IN,
		S_PG_NEXT,
		S_PG_NEXT_R,
		S_FIN,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

### design/array_linked_list_manager.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata fields (low bit up)                               tuser
// s_*      in   cmd[3:0] value[35:4] position[43:36]                     -
// m_*      out  status[1:0] found_index[9:2] found_valid[10]
//               current_index[18:11] current_valid[19] current_data[51:20] -
//
// A sequencer walks the list through one registered read port on the slot memories,
// one link per cycle. Clear frees the nodes one by one from the head, and purge
// walks the rest of the list once for each node's key.
// s_tready is high only while the block is idle; a result item is held until taken.
// Reset empties the list at once; slot memories need no clearing.

module array_linked_list_manager #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	// cmd[3:0], value[35:4], position[43:36], zero pad
	input  wire logic [alm_pkg::IN_TDATA_W-1:0]    s_tdata,
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	// status[1:0], found_index[9:2], found_valid[10], current_index[18:11],
	// current_valid[19], current_data[51:20], zero pad
	output      logic [alm_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import alm_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] NIL = PW'(DEPTH);

	state_t state_q, state_d;

	logic [PW-1:0] head_q, cur_q, hw_q, ftop_q;
	logic [PW-1:0] p_q, pre_q, q_q, found_q;
	logic [3:0]    cmd_q;
	logic [DATA_WIDTH-1:0] val_q, key_q;
	logic [7:0]    rem_q;
	logic [1:0]    status_q;
	logic          front_q;

	logic [DATA_WIDTH-1:0] node_data [DEPTH];
	logic [PW-1:0]         node_link [DEPTH];
	logic [PW-1:0]         free_link [DEPTH];
	logic [DATA_WIDTH-1:0] rdd_q;
	logic [PW-1:0]         rdl_q, rdf_q;

	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          nd_we, nl_we, fl_we;
	logic [IW-1:0] nd_addr, nl_addr, fl_addr;
	logic [PW-1:0] nl_wdata, fl_wdata;

	logic in_acc, avail, cur_valid;

	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = (state_q == S_OUT);
	assign avail     = (ftop_q != NIL) || (hw_q < NIL);
	assign cur_valid = (cur_q != NIL);

	assign m_tdata = {4'd0,
		cur_valid ? 32'(rdd_q) : 32'd0,
		cur_valid,
		cur_valid ? 8'(cur_q) : 8'd0,
		found_q != NIL,
		(found_q != NIL) ? 8'(found_q) : 8'd0,
		status_q};

	// Slot memories with registered reads.
	always_ff @(posedge clk) begin
		if (nd_we)
			node_data[nd_addr] <= val_q;
		if (nl_we)
			node_link[nl_addr] <= nl_wdata;
		if (fl_we)
			free_link[fl_addr] <= fl_wdata;
		if (rd_en) begin
			rdd_q <= node_data[rd_addr];
			rdl_q <= node_link[rd_addr];
			rdf_q <= free_link[rd_addr];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_acc) state_d = S_DISP;
			S_DISP: begin
				case (cmd_q)
					CMD_INS_FRONT, CMD_INS_REAR: begin
						if (!avail)
							state_d = S_FIN;
						else if (cmd_q == CMD_INS_FRONT || head_q == NIL)
							state_d = S_TAKE;
						else
							state_d = S_TAIL_R;
					end
					CMD_REM_FRONT: state_d = (head_q == NIL) ? S_FIN : S_DROP;
					CMD_REM_REAR:  state_d = (head_q == NIL) ? S_FIN : S_RR_R1;
					CMD_REM_CUR: begin
						if (cur_q == NIL || head_q == NIL)
							state_d = S_FIN;
						else if (cur_q == head_q)
							state_d = S_DROP;
						else
							state_d = S_RC_R;
					end
					CMD_SEARCH:   state_d = (head_q == NIL) ? S_FIN : S_SR_R;
					CMD_RETRIEVE: state_d = (head_q == NIL) ? S_FIN : S_RT_R;
					CMD_PURGE:    state_d = (head_q == NIL) ? S_FIN : S_PG_KEY;
					CMD_CLEAR:    state_d = (head_q == NIL) ? S_FIN : S_DROP;
					default:      state_d = S_FIN;
				endcase
			end
			S_TAIL_R: if (rdl_q == NIL) state_d = S_TAKE;
			S_TAKE:   state_d = (ftop_q != NIL) ? S_TAKE_R : S_PLACE;
			S_TAKE_R: state_d = S_PLACE;
			S_PLACE:  state_d = front_q ? S_FIN : S_LINKP;
			S_LINKP:  state_d = S_FIN;
			S_DROP:   state_d = S_DROP_R;
			S_DROP_R: state_d = (cmd_q == CMD_CLEAR && rdl_q != NIL) ? S_DROP : S_FIN;
			S_RR_R1:  state_d = (rdl_q == NIL) ? S_DROP : S_RR_R2;
			S_RR_R2:  if (rdl_q == NIL) state_d = S_FIN;
			S_RC_R: begin
				if (rdl_q == cur_q)
					state_d = S_RC_R2;
				else if (rdl_q == NIL)
					state_d = S_FIN;
			end
			S_RC_R2:  state_d = S_FIN;
			S_SR_R:   if (rdd_q == val_q || rdl_q == NIL) state_d = S_FIN;
			S_RT_R:   if (rem_q == 8'd0 || rdl_q == NIL) state_d = S_FIN;
			S_PG_KEY: state_d = (rdl_q == NIL) ? S_FIN : S_PG_IN;
			S_PG_IN:  if (rdl_q == NIL) state_d = S_PG_NEXT;
			S_PG_NEXT:   state_d = S_PG_NEXT_R;
			S_PG_NEXT_R: state_d = (rdl_q == NIL) ? S_FIN : S_PG_KEY;
			S_FIN:    state_d = S_OUT;
			S_OUT:    if (m_tready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = head_q[IW-1:0];
		nd_we    = 1'b0;
		nd_addr  = q_q[IW-1:0];
		nl_we    = 1'b0;
		nl_addr  = q_q[IW-1:0];
		nl_wdata = NIL;
		fl_we    = 1'b0;
		fl_addr  = head_q[IW-1:0];
		fl_wdata = ftop_q;
		unique case (state_q)
			S_DISP: begin
				rd_en = (head_q != NIL);
			end
			S_TAIL_R, S_RR_R2, S_RC_R, S_SR_R, S_RT_R, S_PG_IN: begin
				rd_en   = (rdl_q != NIL);
				rd_addr = rdl_q[IW-1:0];
				if (state_q == S_RC_R && rdl_q == cur_q)
					rd_addr = cur_q[IW-1:0];
				if (state_q == S_RR_R2 && rdl_q == NIL) begin
					nl_we   = 1'b1;
					nl_addr = pre_q[IW-1:0];
					fl_we   = 1'b1;
					fl_addr = p_q[IW-1:0];
				end
				if (state_q == S_PG_IN && rdd_q == key_q) begin
					nl_we    = 1'b1;
					nl_addr  = pre_q[IW-1:0];
					nl_wdata = rdl_q;
					fl_we    = 1'b1;
					fl_addr  = q_q[IW-1:0];
				end
			end
			S_RR_R1, S_PG_KEY, S_PG_NEXT_R: begin
				rd_en   = (rdl_q != NIL);
				rd_addr = rdl_q[IW-1:0];
			end
			S_TAKE: begin
				rd_en   = (ftop_q != NIL);
				rd_addr = ftop_q[IW-1:0];
			end
			S_PLACE: begin
				nd_we    = 1'b1;
				nl_we    = 1'b1;
				nl_wdata = front_q ? head_q : NIL;
			end
			S_LINKP: begin
				nl_we    = 1'b1;
				nl_addr  = p_q[IW-1:0];
				nl_wdata = q_q;
			end
			S_DROP: rd_en = 1'b1;
			S_DROP_R: fl_we = 1'b1;
			S_RC_R2: begin
				nl_we    = 1'b1;
				nl_addr  = p_q[IW-1:0];
				nl_wdata = rdl_q;
				fl_we    = 1'b1;
				fl_addr  = cur_q[IW-1:0];
			end
			S_PG_NEXT: begin
				rd_en   = 1'b1;
				rd_addr = p_q[IW-1:0];
			end
			S_FIN: begin
				rd_en   = cur_valid;
				rd_addr = cur_q[IW-1:0];
			end
			default: ;
		endcase
	end

	// List pointers and the free stack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= NIL;
			cur_q   <= NIL;
			hw_q    <= '0;
			ftop_q  <= NIL;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_DISP: begin
					if (cmd_q == CMD_CLEAR)
						cur_q <= NIL;
				end
				S_TAKE: if (ftop_q == NIL) hw_q <= hw_q + PW'(1);
				S_TAKE_R: ftop_q <= rdf_q;
				S_PLACE: begin
					cur_q <= q_q;
					if (front_q)
						head_q <= q_q;
				end
				S_DROP_R: begin
					ftop_q <= head_q;
					head_q <= rdl_q;
					cur_q  <= rdl_q;
				end
				S_RR_R2: begin
					if (rdl_q == NIL) begin
						ftop_q <= p_q;
						cur_q  <= pre_q;
					end
				end
				S_RC_R2: begin
					ftop_q <= cur_q;
					cur_q  <= p_q;
				end
				S_SR_R: if (rdd_q == val_q) cur_q <= p_q;
				S_RT_R: if (rem_q == 8'd0) cur_q <= p_q;
				S_PG_KEY: if (rdl_q == NIL) cur_q <= head_q;
				S_PG_IN: if (rdd_q == key_q) ftop_q <= q_q;
				S_PG_NEXT_R: if (rdl_q == NIL) cur_q <= head_q;
				default: ;
			endcase
		end
	end

	// Walk and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cmd_q    <= s_tdata[3:0];
					val_q    <= DATA_WIDTH'(s_tdata[35:4]);
					rem_q    <= s_tdata[43:36];
					status_q <= ST_OK;
					found_q  <= NIL;
				end
			end
			S_DISP: begin
				p_q     <= head_q;
				front_q <= (cmd_q == CMD_INS_FRONT) || (head_q == NIL);
				case (cmd_q)
					CMD_INS_FRONT, CMD_INS_REAR: if (!avail) status_q <= ST_FULL;
					CMD_REM_FRONT, CMD_REM_REAR, CMD_SEARCH, CMD_RETRIEVE:
						if (head_q == NIL) status_q <= ST_NOT_FOUND;
					CMD_REM_CUR: if (cur_q == NIL || head_q == NIL) status_q <= ST_NO_CUR;
					default: ;
				endcase
			end
			S_TAIL_R: if (rdl_q != NIL) p_q <= rdl_q;
			S_TAKE: if (ftop_q == NIL) q_q <= hw_q;
			S_TAKE_R: q_q <= ftop_q;
			S_RR_R1: begin
				pre_q <= head_q;
				p_q   <= rdl_q;
			end
			S_RR_R2: begin
				if (rdl_q != NIL) begin
					pre_q <= p_q;
					p_q   <= rdl_q;
				end
			end
			S_RC_R: begin
				if (rdl_q == NIL)
					status_q <= ST_NO_CUR;
				else if (rdl_q != cur_q)
					p_q <= rdl_q;
			end
			S_SR_R: begin
				if (rdd_q == val_q)
					found_q <= p_q;
				else if (rdl_q == NIL)
					status_q <= ST_NOT_FOUND;
				else
					p_q <= rdl_q;
			end
			S_RT_R: begin
				if (rem_q == 8'd0)
					found_q <= p_q;
				else if (rdl_q == NIL)
					status_q <= ST_NOT_FOUND;
				else begin
					rem_q <= rem_q - 8'd1;
					p_q   <= rdl_q;
				end
			end
			S_PG_KEY: begin
				key_q <= rdd_q;
				pre_q <= p_q;
				q_q   <= rdl_q;
			end
			S_PG_IN: begin
				// A duplicate is unlinked and pre stays; otherwise pre moves on.
				if (rdd_q != key_q)
					pre_q <= q_q;
				q_q <= rdl_q;
			end
			S_PG_NEXT_R: p_q <= rdl_q;
			default: ;
		endcase
	end

endmodule

`default_nettype wire
